// ===== rtl/tcld_pkg.sv =====
package tcld_pkg;

  localparam int LINE_BYTES_DEF  = 20;
  localparam int WORD_MAX_DEF    = 18;
  localparam int OPERAND_MAX_DEF = 19;

  localparam int CMD_COUNT = 4;

  localparam logic [7:0] CH_NUL     = 8'd0;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_STEP  = 8'h20;

  // Number reported for an empty operand: nothing minus the code of '0'.
  localparam logic [31:0] NUM_EMPTY = 32'hFFFF_FFD0;

  // Command words, lower case, padded with zeros. Bit k of the match flags
  // belongs to row k.
  localparam logic [7:0] CMD_TEXT [CMD_COUNT][8] = '{
    '{"l", "c", "d", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"s", "e", "r", "v", "o", 8'd0, 8'd0, 8'd0},
    '{"l", "e", "d", "o", "n", 8'd0, 8'd0, 8'd0},
    '{"l", "e", "d", "o", "f", "f", 8'd0, 8'd0}
  };
  localparam logic [2:0] CMD_LEN [CMD_COUNT] = '{3'd3, 3'd5, 3'd5, 3'd6};

  localparam int CMD_LCD    = 0;
  localparam int CMD_SERVO  = 1;
  localparam int CMD_LED_ON = 2;
  localparam int CMD_LEDOFF = 3;

  typedef enum logic [2:0] {
    ACT_LCD_CLEAR = 3'd0,
    ACT_LCD_CHAR  = 3'd1,
    ACT_SERVO     = 3'd2,
    ACT_LED_ON    = 3'd3,
    ACT_LED_OFF   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_LCD   = 2'd1,
    KIND_SERVO = 2'd2,
    KIND_LED   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    LD_NONE   = 2'd0,
    LD_SINGLE = 2'd1,
    LD_HEAD   = 2'd2,
    LD_CHAR   = 2'd3
  } load_e;

  typedef struct packed {
    logic  take_byte;
    logic  clear_line;
    load_e load;
    logic  rd_en;
    logic  idx_clr;
    logic  idx_inc;
  } tcld_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  op_empty;
    logic  char_last;
    logic  eol;
    logic  out_free;
  } tcld_sts_t;

endpackage

// ===== rtl/tcld_in_if.sv =====
interface tcld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/tcld_out_if.sv =====
interface tcld_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic signed [31:0] value;
  logic [1:0]        led_number;
  logic              last;

  modport source (output valid, output action, output value, output led_number,
                  output last, input ready);
  modport sink (input valid, input action, input value, input led_number,
                input last, output ready);
endinterface

// ===== rtl/tcld_ram.sv =====
module tcld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 19
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tcld_datapath.sv =====
module tcld_datapath #(
  parameter int LINE_BYTES  = tcld_pkg::LINE_BYTES_DEF,
  parameter int WORD_MAX    = tcld_pkg::WORD_MAX_DEF,
  parameter int OPERAND_MAX = tcld_pkg::OPERAND_MAX_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          rx_byte_i,
  input  tcld_pkg::tcld_cmd_t cmd_i,
  output tcld_pkg::tcld_sts_t sts_o,
  input  logic                res_ready_i,
  output logic                res_valid_o,
  output logic [2:0]          action_o,
  output logic signed [31:0]  value_o,
  output logic [1:0]          led_number_o,
  output logic                last_o
);
  import tcld_pkg::*;

  localparam int LCW = $clog2(LINE_BYTES + 1);
  localparam int WLW = $clog2(WORD_MAX + 1);
  localparam int OLW = $clog2(OPERAND_MAX + 1);
  localparam int AW  = $clog2(OPERAND_MAX);

  logic [LCW-1:0]       line_count_q, line_count_d;
  logic                 space_seen_q, space_seen_d;
  logic [CMD_COUNT-1:0] match_q, match_d;
  logic [WLW-1:0]       word_length_q, word_length_d;
  logic [OLW-1:0]       op_len_q, op_len_d;
  logic [31:0]          acc_q, acc_d;
  logic                 neg_q, neg_d;
  logic [AW-1:0]        idx_q, idx_d;

  logic [7:0]           lower_byte;
  logic [CMD_COUNT-1:0] mismatch;
  logic [CMD_COUNT-1:0] hit;
  logic [31:0]          num;
  logic                 led_ok;
  kind_e                kind;
  logic                 ram_we;
  logic [7:0]           ram_rdata;

  logic                 res_valid_q;
  action_e              action_q;
  logic [31:0]          value_q;
  logic [1:0]           led_q;
  logic                 last_q;
  logic                 out_free;

  // Case-folded byte and its comparison against each command word.
  always_comb begin
    lower_byte = rx_byte_i;
    if (rx_byte_i inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      lower_byte = rx_byte_i + CASE_STEP;
    end
    for (int k = 0; k < CMD_COUNT; k++) begin
      mismatch[k] = (word_length_q >= WLW'(CMD_LEN[k])) ||
                    (lower_byte != CMD_TEXT[k][word_length_q[2:0]]);
    end
  end

  always_comb begin
    line_count_d  = line_count_q;
    space_seen_d  = space_seen_q;
    match_d       = match_q;
    word_length_d = word_length_q;
    op_len_d      = op_len_q;
    acc_d         = acc_q;
    neg_d         = neg_q;
    ram_we        = 1'b0;

    if (cmd_i.take_byte && rx_byte_i != CH_NUL && line_count_q < LCW'(LINE_BYTES)) begin
      line_count_d = line_count_q + LCW'(1);
      if (!space_seen_q) begin
        // A word that has reached its limit takes the next byte as separator.
        if (rx_byte_i == CH_SPACE || word_length_q >= WLW'(WORD_MAX)) begin
          space_seen_d = 1'b1;
        end else begin
          match_d       = match_q & ~mismatch;
          word_length_d = word_length_q + WLW'(1);
        end
      end else if (op_len_q < OLW'(OPERAND_MAX)) begin
        if (op_len_q == '0) begin
          if (rx_byte_i == CH_MINUS) begin
            neg_d = 1'b1;
          end else begin
            acc_d = {24'd0, rx_byte_i} - {24'd0, CH_ZERO};
          end
        end else begin
          acc_d = (acc_q << 3) + (acc_q << 1) + {24'd0, rx_byte_i} - {24'd0, CH_ZERO};
        end
        ram_we   = 1'b1;
        op_len_d = op_len_q + OLW'(1);
      end
    end

    if (cmd_i.clear_line) begin
      line_count_d  = '0;
      space_seen_d  = 1'b0;
      match_d       = '1;
      word_length_d = '0;
      op_len_d      = '0;
      acc_d         = '0;
      neg_d         = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q  <= '0;
      space_seen_q  <= 1'b0;
      match_q       <= '1;
      word_length_q <= '0;
      op_len_q      <= '0;
      acc_q         <= '0;
      neg_q         <= 1'b0;
    end else begin
      line_count_q  <= line_count_d;
      space_seen_q  <= space_seen_d;
      match_q       <= match_d;
      word_length_q <= word_length_d;
      op_len_q      <= op_len_d;
      acc_q         <= acc_d;
      neg_q         <= neg_d;
    end
  end

  tcld_ram #(
    .WIDTH (8),
    .DEPTH (OPERAND_MAX)
  ) u_operand_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (op_len_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // Line decision, taken from the line state once the carriage return is in.
  always_comb begin
    for (int k = 0; k < CMD_COUNT; k++) begin
      hit[k] = space_seen_q && match_q[k] && (word_length_q == WLW'(CMD_LEN[k]));
    end
    if (op_len_q == '0) begin
      num = NUM_EMPTY;
    end else if (neg_q) begin
      num = 32'd0 - acc_q;
    end else begin
      num = acc_q;
    end
    led_ok = (num[31:2] == '0) && (num[1:0] != 2'd0);
    if (hit[CMD_LCD]) begin
      kind = KIND_LCD;
    end else if (hit[CMD_SERVO]) begin
      kind = KIND_SERVO;
    end else if ((hit[CMD_LED_ON] || hit[CMD_LEDOFF]) && led_ok) begin
      kind = KIND_LED;
    end else begin
      kind = KIND_NONE;
    end
  end

  assign out_free = !res_valid_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.load != LD_NONE) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.load)
      LD_SINGLE: begin
        if (hit[CMD_SERVO]) begin
          action_q <= ACT_SERVO;
          value_q  <= num;
          led_q    <= 2'd0;
        end else begin
          if (hit[CMD_LED_ON]) begin
            action_q <= ACT_LED_ON;
          end else begin
            action_q <= ACT_LED_OFF;
          end
          value_q  <= 32'd0;
          led_q    <= num[1:0];
        end
        last_q <= 1'b1;
      end
      LD_HEAD: begin
        action_q <= ACT_LCD_CLEAR;
        value_q  <= 32'd0;
        led_q    <= 2'd0;
        last_q   <= (op_len_q == '0);
      end
      LD_CHAR: begin
        action_q <= ACT_LCD_CHAR;
        value_q  <= {24'd0, ram_rdata};
        led_q    <= 2'd0;
        last_q   <= sts_o.char_last;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.kind      = kind;
  assign sts_o.op_empty  = (op_len_q == '0);
  assign sts_o.char_last = (OLW'(idx_q) == op_len_q - OLW'(1));
  assign sts_o.eol       = (rx_byte_i == CH_CR);
  assign sts_o.out_free  = out_free;

  assign res_valid_o  = res_valid_q;
  assign action_o     = action_q;
  assign value_o      = value_q;
  assign led_number_o = led_q;
  assign last_o       = last_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load != LD_NONE) |-> out_free)
    else $error("result register overwritten while still held");

  a_load_shows_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load != LD_NONE) |=> res_valid_q)
    else $error("loaded result not presented");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_len_q <= OLW'(OPERAND_MAX)) && (line_count_q <= LCW'(LINE_BYTES)))
    else $error("line or operand count past its capacity");

endmodule

// ===== rtl/tcld_ctrl.sv =====
module tcld_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcld_pkg::tcld_sts_t sts_i,
  output tcld_pkg::tcld_cmd_t cmd_o
);
  import tcld_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_READ   = 4'b0100,
    S_CHAR   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.load = LD_NONE;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (sts_i.eol) begin
            state_d = S_DECIDE;
          end else begin
            cmd_o.take_byte = 1'b1;
          end
        end
      end
      S_DECIDE: begin
        case (sts_i.kind)
          KIND_NONE: begin
            cmd_o.clear_line = 1'b1;
            state_d          = S_IDLE;
          end
          KIND_SERVO, KIND_LED: begin
            if (sts_i.out_free) begin
              cmd_o.load       = LD_SINGLE;
              cmd_o.clear_line = 1'b1;
              state_d          = S_IDLE;
            end
          end
          KIND_LCD: begin
            if (sts_i.out_free) begin
              cmd_o.load = LD_HEAD;
              if (sts_i.op_empty) begin
                cmd_o.clear_line = 1'b1;
                state_d          = S_IDLE;
              end else begin
                cmd_o.idx_clr = 1'b1;
                state_d       = S_READ;
              end
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CHAR;
      end
      S_CHAR: begin
        // The operand byte is held in the memory's read register until taken.
        if (sts_i.out_free) begin
          cmd_o.load = LD_CHAR;
          if (sts_i.char_last) begin
            cmd_o.clear_line = 1'b1;
            state_d          = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_eol_decides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && sts_i.eol) |=> (state_q == S_DECIDE))
    else $error("carriage return did not start the line decision");

  a_no_load_while_taking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (cmd_o.load == LD_NONE))
    else $error("result loaded while input bytes are being taken");

  a_char_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load == LD_CHAR && cmd_o.clear_line) |-> sts_i.char_last)
    else $error("line cleared before its last character was sent");

endmodule

// ===== rtl/text_command_line_decoder.sv =====
// Text command line decoder. Received bytes build a line that splits at the
// first space into a command word (lcd, servo, ledon, ledoff, any letter case)
// and an operand; a carriage return ends the line and sends its results. An
// ordinary byte is taken whenever it is offered in the idle state, and the
// input stays ready while an earlier result waits at the output. After a
// carriage return the input is held off through a decision state, in which
// the first result is loaded once the output is free: a servo or LED line gives
// that one result, and an lcd line with n operand characters follows its
// clear-and-home result with n character results, each read through the operand
// memory's registered read port in a read state and sent from a character state.
// The input stays held off while the output stalls. No result appears for a
// line without a space, an unknown word or an LED number outside 1 to 3.
module text_command_line_decoder #(
  parameter int LINE_BYTES  = tcld_pkg::LINE_BYTES_DEF,
  parameter int WORD_MAX    = tcld_pkg::WORD_MAX_DEF,
  parameter int OPERAND_MAX = tcld_pkg::OPERAND_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcld_in_if.sink     rx_i,
  tcld_out_if.source  res_o
);
  import tcld_pkg::*;

  tcld_cmd_t cmd;
  tcld_sts_t sts;

  tcld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcld_datapath #(
    .LINE_BYTES  (LINE_BYTES),
    .WORD_MAX    (WORD_MAX),
    .OPERAND_MAX (OPERAND_MAX)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_i.rx_byte),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_ready_i  (res_o.ready),
    .res_valid_o  (res_o.valid),
    .action_o     (res_o.action),
    .value_o      (res_o.value),
    .led_number_o (res_o.led_number),
    .last_o       (res_o.last)
  );

endmodule
